// ===== src/fqrk_pkg.sv =====
// shared types and constants for the fifo queue with remove by key
// no dependencies
package fqrk_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PID_W          = 16;
    localparam int IN_DATA_W      = 32;
    localparam int OCC_W          = 5;

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_REM  = 2'd3
    } t_mode;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_HEAD     = 6'b000100,
        S_SCAN     = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_SHIFT_RD = 6'b100000
    } t_state;

    // ram address source: offset from head
    typedef enum logic [1:0] {
        ADDR_K    = 2'd0,
        ADDR_K1   = 2'd1,
        ADDR_TAIL = 2'd2
    } t_addr_sel;

    typedef struct packed {
        logic      load_req;
        t_addr_sel addr_sel;
        logic      mem_wr;
        logic      wr_shift;
        logic      k_inc;
        logic      head_inc;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      res_load;
        logic      res_ok;
        logic      res_head;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  match;
        logic  k_last;
    } t_dp_sts;

endpackage

// ===== src/fifo_queue_with_remove_by_key_core.sv =====
// enqueue is settled in the decode state and writes at the tail unless full; dequeue and peek read the head;
// remove scans from the head for the key and, on a match, shifts each later entry one place toward
// the head to close the gap; dequeue, peek and remove on an empty queue end in the decode state;
// the entry store is single port; one request at a time; busy is high from accept until the result
// o_done pulses for one cycle; the receiver cannot stall; a new start is taken in that cycle
// synchronous active low reset empties the queue; entry store is not cleared
module fifo_queue_with_remove_by_key_core
    import fqrk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_mode,
    input  logic [PID_W-1:0]     i_pid,
    input  logic [IN_DATA_W-1:0] i_entry_data,
    // result channel
    output logic                 o_done,
    output logic                 o_ok,
    output logic [PID_W-1:0]     o_out_pid,
    output logic [IN_DATA_W-1:0] o_out_data,
    output logic [OCC_W-1:0]     o_occupancy,
    output logic                 o_empty_flag
);

    // command and status between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: decode, head read, scan for key, close the gap
    fqrk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // circular store: head pointer plus count, entries addressed from head
    fqrk_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_pid        (i_pid),
        .i_entry_data (i_entry_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_out_pid    (o_out_pid),
        .o_out_data   (o_out_data),
        .o_occupancy  (o_occupancy),
        .o_empty_flag (o_empty_flag)
    );

endmodule

// ===== src/fqrk_ram.sv =====
// generic single port ram with registered read
// no dependencies
module fqrk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fqrk_ctrl.sv =====
// controller state machine for the fifo queue with remove by key
// depends on fqrk_pkg
module fqrk_ctrl
    import fqrk_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                // address offset k is zero here, so this reads the head
                o_cmd.addr_sel = ADDR_K;
                case (i_sts.mode)
                    MODE_ENQ: begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                        if (!i_sts.full) begin
                            o_cmd.addr_sel = ADDR_TAIL;
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.cnt_inc  = 1'b1;
                            o_cmd.res_ok   = 1'b1;
                        end
                    end
                    MODE_DEQ, MODE_PEEK: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_HEAD;
                        end
                    end
                    default: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_HEAD: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_ok   = 1'b1;
                o_cmd.res_head = 1'b1;
                if (i_sts.mode == MODE_DEQ) begin
                    o_cmd.head_inc = 1'b1;
                    o_cmd.cnt_dec  = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // prefetch the following entry while comparing this one
                o_cmd.addr_sel = ADDR_K1;
                if (i_sts.match) begin
                    if (i_sts.k_last) begin
                        o_cmd.cnt_dec  = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_ok   = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_SHIFT_WR;
                    end
                end else if (i_sts.k_last) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.addr_sel = ADDR_K;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.wr_shift = 1'b1;
                o_cmd.k_inc    = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                o_cmd.addr_sel = ADDR_K1;
                if (i_sts.k_last) begin
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_ok   = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/fqrk_dp.sv =====
// datapath: circular entry store, pointers, scan index and result registers
// depends on fqrk_pkg and fqrk_ram
module fqrk_dp
    import fqrk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_mode,
    input  logic [PID_W-1:0]     i_pid,
    input  logic [IN_DATA_W-1:0] i_entry_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_done,
    output logic                 o_ok,
    output logic [PID_W-1:0]     o_out_pid,
    output logic [IN_DATA_W-1:0] o_out_data,
    output logic [OCC_W-1:0]     o_occupancy,
    output logic                 o_empty_flag
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = PID_W + DATA_WIDTH;

    t_mode                 r_mode;
    logic [PID_W-1:0]      r_pid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_k;
    logic                  r_done;
    logic                  r_ok;
    logic [PID_W-1:0]      r_out_pid;
    logic [IN_DATA_W-1:0]  r_out_data;

    logic [CW-1:0]         k_next;
    logic [CW-1:0]         offset;
    logic [AW:0]           addr_sum;
    logic [AW-1:0]         addr;
    logic [EW-1:0]         wdata;
    logic [EW-1:0]         rdata;
    logic [PID_W-1:0]      rd_pid;
    logic [DATA_WIDTH-1:0] rd_data;

    assign k_next = r_k + CW'(1);

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_K:    offset = r_k;
            ADDR_K1:   offset = k_next;
            ADDR_TAIL: offset = r_count;
            default:   offset = r_k;
        endcase
    end

    // head plus offset, wrapped once around the store
    always_comb begin
        addr_sum = {1'b0, r_head} + (AW + 1)'(offset);
        if (addr_sum >= (AW + 1)'(DEPTH)) begin
            addr_sum = addr_sum - (AW + 1)'(DEPTH);
        end
    end

    assign addr  = addr_sum[AW-1:0];
    assign wdata = i_cmd.wr_shift ? rdata : {r_pid, r_data};

    fqrk_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign rd_pid  = rdata[EW-1:DATA_WIDTH];
    assign rd_data = rdata[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= t_mode'(i_mode);
            r_pid  <= i_pid;
            r_data <= DATA_WIDTH'(i_entry_data);
        end
        if (i_cmd.res_load) begin
            r_ok       <= i_cmd.res_ok;
            r_out_pid  <= i_cmd.res_head ? rd_pid : '0;
            r_out_data <= i_cmd.res_head ? IN_DATA_W'(rd_data) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.res_load;
            if (i_cmd.load_req) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= k_next;
            end
            if (i_cmd.head_inc) begin
                r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_sts.mode   = r_mode;
    assign o_sts.full   = (r_count == CW'(DEPTH));
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.match  = (rd_pid == r_pid);
    assign o_sts.k_last = (k_next == r_count);

    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_out_pid    = r_out_pid;
    assign o_out_data   = r_out_data;
    assign o_occupancy  = OCC_W'(r_count);
    assign o_empty_flag = (r_count == '0);

endmodule

// ===== tb/sv/fifo_queue_with_remove_by_key_core_test.sv =====
// self-checking testbench for fifo_queue_with_remove_by_key_core
// runs directed and random queue requests against an internal ready queue predictor
// depends on fqrk_pkg and the core only
module fifo_queue_with_remove_by_key_core_test;
    import fqrk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int SETTLE_CYC = 40;   // settling margin, longer than the slowest remove on a full store

    // one request as the sender sees it, with its pacing
    typedef struct {
        t_mode                mode;
        logic [PID_W-1:0]     pid;
        logic [IN_DATA_W-1:0] data;
        int                   gap;    // idle cycles before this request is offered
        bit                   drain;  // hold off until every result is back
    } t_request;

    // one result as the core should report it
    typedef struct {
        logic                 ok;
        logic [PID_W-1:0]     pid;
        logic [IN_DATA_W-1:0] data;
        logic [OCC_W-1:0]     occ;
        logic                 empty;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_mode = '0;
    logic [PID_W-1:0]     i_pid = '0;
    logic [IN_DATA_W-1:0] i_entry_data = '0;
    logic                 o_done;
    logic                 o_ok;
    logic [PID_W-1:0]     o_out_pid;
    logic [IN_DATA_W-1:0] o_out_data;
    logic [OCC_W-1:0]     o_occupancy;
    logic                 o_empty_flag;

    fifo_queue_with_remove_by_key_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_pid        (i_pid),
        .i_entry_data (i_entry_data),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_out_pid    (o_out_pid),
        .o_out_data   (o_out_data),
        .o_occupancy  (o_occupancy),
        .o_empty_flag (o_empty_flag)
    );

    always #1 i_clk = ~i_clk;

    // requests waiting to be offered, results waiting to arrive
    t_request pending[$];
    t_outcome outcomes[$];

    // shadow copy of the ready queue, head at index 0
    logic [PID_W-1:0]     slot_pid [DEPTH];
    logic [IN_DATA_W-1:0] slot_data[DEPTH];
    int                   held = 0;

    int gap_left   = 0;
    int n_sent     = 0;   // requests accepted, updated at the clock edge
    int n_seen     = 0;   // results strobed, updated at the clock edge
    int mismatches = 0;

    // coverage tallies for the closing summary
    int n_by_mode[4];
    int n_ok       = 0;
    int n_full_ref = 0;
    int n_on_empty = 0;
    int n_no_match = 0;
    int max_held   = 0;

    // apply one request to the shadow queue and return what the core must report
    function automatic t_outcome apply_request(t_request rq);
        t_outcome res;
        int       hit;
        res = '{ok: 1'b0, pid: '0, data: '0, occ: '0, empty: 1'b0};
        n_by_mode[rq.mode]++;
        case (rq.mode)
            MODE_ENQ: begin
                if (held < DEPTH) begin
                    slot_pid[held]  = rq.pid;
                    slot_data[held] = rq.data;
                    held++;
                    res.ok = 1'b1;
                end else begin
                    n_full_ref++;
                end
            end
            MODE_DEQ, MODE_PEEK: begin
                if (held > 0) begin
                    res.ok   = 1'b1;
                    res.pid  = slot_pid[0];
                    res.data = slot_data[0];
                    if (rq.mode == MODE_DEQ) begin
                        for (int i = 1; i < held; i++) begin
                            slot_pid[i-1]  = slot_pid[i];
                            slot_data[i-1] = slot_data[i];
                        end
                        held--;
                    end
                end else begin
                    n_on_empty++;
                end
            end
            default: begin
                // first match nearest the head wins, the gap closes behind it
                hit = -1;
                for (int i = 0; i < held; i++) begin
                    if (hit < 0 && slot_pid[i] == rq.pid)
                        hit = i;
                end
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < held; i++) begin
                        slot_pid[i]  = slot_pid[i+1];
                        slot_data[i] = slot_data[i+1];
                    end
                    held--;
                    res.ok = 1'b1;
                end else begin
                    n_no_match++;
                end
            end
        endcase
        if (res.ok)
            n_ok++;
        if (held > max_held)
            max_held = held;
        res.occ   = OCC_W'(held);
        res.empty = (held == 0);
        return res;
    endfunction

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    task automatic check_field(string what, logic [IN_DATA_W-1:0] want,
                               logic [IN_DATA_W-1:0] got);
        if (got !== want)
            note_mismatch(what, 64'(want), 64'(got));
    endtask

    task automatic offer(t_request rq);
        start        <= 1'b1;
        i_mode       <= rq.mode;
        i_pid        <= rq.pid;
        i_entry_data <= rq.data;
    endtask

    // driver: a request is taken at an edge with start high and busy low
    always @(posedge i_clk) begin : driver
        t_request nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            outcomes.push_back(apply_request(pending.pop_front()));
            n_sent <= n_sent + 1;
            if (pending.size() != 0) begin
                nxt = pending[0];
                // back to back: keep start high and swap the payload in one step
                if (nxt.gap == 0 && !nxt.drain) begin
                    offer(nxt);
                end else begin
                    start    <= 1'b0;
                    gap_left <= nxt.gap;
                end
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (pending.size() != 0 && (!pending[0].drain || n_sent == n_seen)) begin
                offer(pending[0]);
            end
        end
    end

    // monitor: o_done marks a single cycle result, the oldest expectation must match
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (outcomes.size() == 0) begin
                note_mismatch("result with no request outstanding", 64'd0, 64'(o_occupancy));
            end else begin
                want = outcomes.pop_front();
                check_field("ok", IN_DATA_W'(want.ok), IN_DATA_W'(o_ok));
                check_field("out_pid", IN_DATA_W'(want.pid), IN_DATA_W'(o_out_pid));
                check_field("out_data", want.data, o_out_data);
                check_field("occupancy", IN_DATA_W'(want.occ), IN_DATA_W'(o_occupancy));
                check_field("empty_flag", IN_DATA_W'(want.empty), IN_DATA_W'(o_empty_flag));
            end
            n_seen <= n_seen + 1;
        end
    end

    task automatic add_request(t_mode m, logic [PID_W-1:0] p, logic [IN_DATA_W-1:0] d,
                               int g, bit dr);
        t_request rq;
        rq.mode  = m;
        rq.pid   = p;
        rq.data  = d;
        rq.gap   = g;
        rq.drain = dr;
        pending.push_back(rq);
    endtask

    // stimulus, reset and end of run
    initial begin : stimulus
        logic [PID_W-1:0] pid_pool[8];
        int               bias;
        bit               burst;
        int               r;
        int               g;
        t_mode            m;
        logic [PID_W-1:0] p;

        pid_pool = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
                     16'h5a5a, 16'ha5a5, 16'h00ff, 16'h1234};

        // directed: empty store, fill to the brim, full refusal, removal corners
        add_request(MODE_DEQ, 16'h0000, 32'h0, 0, 0);
        add_request(MODE_PEEK, 16'hffff, 32'hffff_ffff, 0, 0);
        add_request(MODE_REM, 16'h0000, 32'h0, 0, 0);
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0)
                add_request(MODE_ENQ, 16'h0000, 32'h0000_0000, 0, 0);
            else if (i == 1)
                add_request(MODE_ENQ, 16'hffff, 32'hffff_ffff, 1, 0);
            else if (i == 3 || i == 6)
                add_request(MODE_ENQ, 16'h00a5, $urandom, 0, 0);   // duplicate ids
            else
                add_request(MODE_ENQ, 16'h0100 + PID_W'(i), $urandom, i % 3, 0);
        end
        add_request(MODE_ENQ, 16'hffff, 32'hffff_ffff, 0, 0);      // refused when full
        add_request(MODE_PEEK, 16'h0000, 32'h0, 2, 0);
        add_request(MODE_REM, 16'h1357, 32'h0, 0, 0);              // no such id
        add_request(MODE_REM, 16'h00a5, 32'h0, 0, 0);              // first of two
        add_request(MODE_REM, 16'h010f, 32'h0, 0, 0);              // tail entry
        add_request(MODE_REM, 16'h0000, 32'h0, 0, 0);              // head entry
        add_request(MODE_DEQ, 16'h0000, 32'h0, 0, 1);

        // random: phases that lean toward filling, draining, balance or removal
        for (int ph = 0; ph < 16; ph++) begin
            bias  = $urandom_range(0, 3);
            burst = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < 100; k++) begin
                r = $urandom_range(0, 99);
                case (bias)
                    0:       m = (r < 60) ? MODE_ENQ : (r < 75) ? MODE_DEQ :
                                 (r < 85) ? MODE_PEEK : MODE_REM;
                    1:       m = (r < 20) ? MODE_ENQ : (r < 70) ? MODE_DEQ :
                                 (r < 80) ? MODE_PEEK : MODE_REM;
                    2:       m = (r < 40) ? MODE_ENQ : (r < 65) ? MODE_DEQ :
                                 (r < 80) ? MODE_PEEK : MODE_REM;
                    default: m = (r < 45) ? MODE_ENQ : (r < 55) ? MODE_DEQ :
                                 (r < 65) ? MODE_PEEK : MODE_REM;
                endcase
                // a small id pool keeps removals hitting and duplicates common
                p = ($urandom_range(0, 3) == 0) ? PID_W'($urandom) : pid_pool[$urandom_range(0, 7)];
                g = burst ? 0 : $urandom_range(0, 11);
                add_request(m, p, $urandom, g, (k == 0 && (ph == 0 || $urandom_range(0, 2) == 0)));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the active edge so the exit does not race the driver
        while (pending.size() != 0 || start || n_seen != n_sent)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (outcomes.size() != 0)
            note_mismatch("results never arrived", 64'(outcomes.size()), 64'd0);

        $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d remove",
                 n_sent, n_by_mode[MODE_ENQ], n_by_mode[MODE_DEQ],
                 n_by_mode[MODE_PEEK], n_by_mode[MODE_REM]);
        $display("%0d succeeded, %0d full refusals, %0d on empty, %0d removes missed, peak %0d",
                 n_ok, n_full_ref, n_on_empty, n_no_match, max_held);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("timeout with %0d requests still queued", pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
src/fqrk_pkg.sv
src/fqrk_ram.sv
src/fqrk_ctrl.sv
src/fqrk_dp.sv
src/fifo_queue_with_remove_by_key_core.sv
tb/sv/fifo_queue_with_remove_by_key_core_test.sv
